// ===== src/tcl_pkg.sv =====
package tcl_pkg;

    // Item field widths
    localparam int OP_W   = 2;
    localparam int SMP_W  = 8;
    localparam int SEC_W  = 16;
    localparam int TPS_W  = 8;
    localparam int REC_W  = SEC_W + SMP_W;

    // Input operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    // Result kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    // Reset value of the ticks per second register
    localparam logic [TPS_W-1:0] TPS_RESET = 8'd20;

    // Commands from controller to datapath
    typedef struct packed {
        logic tick;
        logic sample;
        logic dump;
        logic load_rd;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sample_new;
        logic            log_empty;
    } t_status;

endpackage

// ===== src/tcl_if.sv =====
interface tcl_in_if import tcl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [SMP_W-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink (input valid, input op, input sample, output ready);
endinterface

interface tcl_out_if import tcl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [SEC_W-1:0] seconds;
    logic [SMP_W-1:0] value;
    logic             last;

    modport source (output valid, output kind, output seconds, output value, output last,
                    input ready);
    modport sink (input valid, input kind, input seconds, input value, input last,
                  output ready);
endinterface

// ===== src/tcl_ctrl.sv =====
module tcl_ctrl import tcl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_acc;

    // Take an item when idle and the output register is free or being emptied
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Decode the accepted item into datapath commands
    always_comb begin
        o_cmd.tick    = w_acc && (i_status.op == OP_TICK);
        o_cmd.sample  = w_acc && (i_status.op == OP_SAMPLE) && i_status.sample_new;
        o_cmd.dump    = w_acc && (i_status.op == OP_DUMP) && !i_status.log_empty;
        o_cmd.load_rd = (r_state == ST_READ);
    end

    // On a dump, pass through the read state for the log read data
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = o_cmd.dump ? ST_READ : ST_IDLE;
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold the result until the sink takes it
    always_comb begin
        if (o_cmd.sample || o_cmd.load_rd) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/tcl_dpath.sv =====
module tcl_dpath import tcl_pkg::*; #(
    parameter int LOG_DEPTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [OP_W-1:0]  i_op,
    input  logic [SMP_W-1:0] i_sample,
    input  logic             i_cfg_we,
    input  logic [TPS_W-1:0] i_cfg_wdata,
    output t_status          o_status,
    output logic             o_kind,
    output logic [SEC_W-1:0] o_seconds,
    output logic [SMP_W-1:0] o_value,
    output logic             o_last
);

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);

    logic [TPS_W-1:0] r_tps;
    logic [TPS_W-1:0] r_tick;
    logic [TPS_W-1:0] n_tick;
    logic [SEC_W-1:0] r_seconds;
    logic             r_have_prev;
    logic [SMP_W-1:0] r_prev;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_read_index;
    logic             r_dump_last;
    logic [REC_W-1:0] r_rd_data;
    logic [REC_W-1:0] r_mem [LOG_DEPTH];

    logic             w_full;
    logic [AW-1:0]    w_rd_idx;
    logic [CW-1:0]    w_rd_next;
    logic             w_rd_last;

    // Report item status to the controller
    always_comb begin
        o_status.op         = i_op;
        o_status.sample_new = !r_have_prev || (i_sample != r_prev);
        o_status.log_empty  = (r_count == '0);
    end

    assign n_tick = r_tick + TPS_W'(1);
    assign w_full = (r_count == CW'(LOG_DEPTH));

    // Pick the dump address, wrapping to zero past the fill count
    assign w_rd_idx  = (CW'(r_read_index) >= r_count) ? '0 : r_read_index;
    assign w_rd_next = CW'(w_rd_idx) + CW'(1);
    assign w_rd_last = (w_rd_next >= r_count);

    // Load ticks per second, advance the seconds clock, track samples and the dump pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= TPS_RESET;
            r_tick       <= '0;
            r_seconds    <= '0;
            r_have_prev  <= 1'b0;
            r_prev       <= '0;
            r_count      <= '0;
            r_read_index <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            if (i_cmd.tick) begin
                if (n_tick >= r_tps) begin
                    r_tick    <= '0;
                    r_seconds <= r_seconds + SEC_W'(1);
                end else begin
                    r_tick <= n_tick;
                end
            end
            if (i_cmd.sample) begin
                r_have_prev <= 1'b1;
                r_prev      <= i_sample;
                if (!w_full) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.dump) begin
                r_read_index <= w_rd_last ? '0 : w_rd_next[AW-1:0];
            end
        end
    end

    // Log memory: append on a changed sample while not full, registered read on a dump
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample && !w_full) begin
            r_mem[r_count[AW-1:0]] <= {r_seconds, i_sample};
        end
        if (i_cmd.dump) begin
            r_rd_data   <= r_mem[w_rd_idx];
            r_dump_last <= w_rd_last;
        end
    end

    // Load the output register with an update or a dumped record
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample) begin
            o_kind    <= KIND_UPDATE;
            o_seconds <= r_seconds;
            o_value   <= i_sample;
            o_last    <= 1'b0;
        end else if (i_cmd.load_rd) begin
            o_kind    <= KIND_RECORD;
            o_seconds <= r_rd_data[REC_W-1:SMP_W];
            o_value   <= r_rd_data[SMP_W-1:0];
            o_last    <= r_dump_last;
        end
    end

endmodule

// ===== src/timestamped_change_logger.sv =====
// Tick and sample items are handled on acceptance; a sample result is valid the cycle after acceptance.
// A dump item passes the log memory read port and registered read data, then the output
// register, before its record is valid. Ticks and samples sustain one item a cycle while
// no result waits in the output register; a waiting result blocks new items until taken.
// Synchronous active-low reset clears the counters, the fill count and the dump pointer and
// sets ticks per second to 20; the log memory is not cleared, the fill count guards reads.
module timestamped_change_logger import tcl_pkg::*; #(
    parameter int LOG_DEPTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TPS_W-1:0] i_cfg_wdata,
    tcl_in_if.sink           i_in,
    tcl_out_if.source        o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    tcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    tcl_dpath #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_op        (i_in.op),
        .i_sample    (i_in.sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (w_status),
        .o_kind      (o_out.kind),
        .o_seconds   (o_out.seconds),
        .o_value     (o_out.value),
        .o_last      (o_out.last)
    );

endmodule

// ===== src/tcl_checker.sv =====
module tcl_checker import tcl_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic [OP_W-1:0]  i_in_op,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_kind,
    input logic [SEC_W-1:0] i_out_seconds,
    input logic [SMP_W-1:0] i_out_value,
    input logic             i_out_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_seconds) && $stable(i_out_value) && $stable(i_out_last))
        else $error("stalled result changed");

    // An update never carries the last flag
    a_update_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_UPDATE) |-> !i_out_last)
        else $error("update result with last flag");

    // No new item while a result is stalled
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("item taken while result stalled");

    // A fresh record traces back to an accepted dump item
    a_record_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) && (i_out_kind == KIND_RECORD)
            |-> $past(i_in_valid && i_in_ready && (i_in_op == OP_DUMP), 2))
        else $error("record without dump item");

endmodule

bind timestamped_change_logger tcl_checker u_tcl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_op       (i_in.op),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.kind),
    .i_out_seconds (o_out.seconds),
    .i_out_value   (o_out.value),
    .i_out_last    (o_out.last)
);
